@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands; the using module provides clk and
// an active-low synchronous rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ypc_pkg.sv @@
// ----------------------------------------------------------------------------
// ypc_pkg
// Types and constants shared by the yellow pixel classifier modules.
// ----------------------------------------------------------------------------
package ypc_pkg;

  localparam int HUE_NUM_W = 19;
  localparam int HUE_DEN_W = 11;
  localparam int SAT_NUM_W = 17;
  localparam int SAT_DEN_W = 9;
  localparam int QUO_W     = 9;
  localparam int PIPE_LATENCY = 3 + QUO_W;

  localparam logic [7:0] HUE_BIAS = 8'd43;

  localparam logic [2:0] REG_HUE_LOW   = 3'd0;
  localparam logic [2:0] REG_HUE_HIGH  = 3'd1;
  localparam logic [2:0] REG_SAT_THR   = 3'd2;
  localparam logic [2:0] REG_VAL_THR   = 3'd3;
  localparam logic [2:0] REG_GB_MARGIN = 3'd4;
  localparam logic [2:0] REG_RB_MARGIN = 3'd5;

  localparam logic [7:0] RST_HUE_LOW   = 8'd30;
  localparam logic [7:0] RST_HUE_HIGH  = 8'd60;
  localparam logic [7:0] RST_SAT_THR   = 8'd110;
  localparam logic [7:0] RST_VAL_THR   = 8'd110;
  localparam logic [7:0] RST_GB_MARGIN = 8'd35;
  localparam logic [7:0] RST_RB_MARGIN = 8'd20;

  typedef enum logic [1:0] {
    SEXT_RED,
    SEXT_GREEN,
    SEXT_BLUE
  } sext_t;

  typedef struct packed {
    logic [7:0] hue_low;
    logic [7:0] hue_high;
    logic [7:0] sat_thr;
    logic [7:0] val_thr;
    logic [7:0] gb_margin;
    logic [7:0] rb_margin;
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    logic [HUE_NUM_W-1:0] hue_num;
    logic [HUE_DEN_W-1:0] hue_den;
    logic [SAT_NUM_W-1:0] sat_num;
    logic [SAT_DEN_W-1:0] sat_den;
    logic                 grey;
    logic                 val_ok;
    logic                 gb_ok;
    logic                 rb_ok;
  } front_t;

endpackage

@@ rtl/core/ypc_cfg.sv @@
// ----------------------------------------------------------------------------
// ypc_cfg
// APB register file holding the six classifier thresholds.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ypc_cfg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output ypc_pkg::cfg_t  cfg
);

  ypc_pkg::cfg_t cfg_r;
  ypc_pkg::cfg_t cfg_nxt;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        ypc_pkg::REG_HUE_LOW:   cfg_nxt.hue_low   = pwdata[7:0];
        ypc_pkg::REG_HUE_HIGH:  cfg_nxt.hue_high  = pwdata[7:0];
        ypc_pkg::REG_SAT_THR:   cfg_nxt.sat_thr   = pwdata[7:0];
        ypc_pkg::REG_VAL_THR:   cfg_nxt.val_thr   = pwdata[7:0];
        ypc_pkg::REG_GB_MARGIN: cfg_nxt.gb_margin = pwdata[7:0];
        ypc_pkg::REG_RB_MARGIN: cfg_nxt.rb_margin = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ypc_pkg::REG_HUE_LOW:   prdata = {24'd0, cfg_r.hue_low};
      ypc_pkg::REG_HUE_HIGH:  prdata = {24'd0, cfg_r.hue_high};
      ypc_pkg::REG_SAT_THR:   prdata = {24'd0, cfg_r.sat_thr};
      ypc_pkg::REG_VAL_THR:   prdata = {24'd0, cfg_r.val_thr};
      ypc_pkg::REG_GB_MARGIN: prdata = {24'd0, cfg_r.gb_margin};
      ypc_pkg::REG_RB_MARGIN: prdata = {24'd0, cfg_r.rb_margin};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hue_low   <= ypc_pkg::RST_HUE_LOW;
      cfg_r.hue_high  <= ypc_pkg::RST_HUE_HIGH;
      cfg_r.sat_thr   <= ypc_pkg::RST_SAT_THR;
      cfg_r.val_thr   <= ypc_pkg::RST_VAL_THR;
      cfg_r.gb_margin <= ypc_pkg::RST_GB_MARGIN;
      cfg_r.rb_margin <= ypc_pkg::RST_RB_MARGIN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  `ASSERT_NXT(a_cfg_hue_low_wr, wr_en && idx == ypc_pkg::REG_HUE_LOW,
              cfg_r.hue_low == $past(pwdata[7:0]), "hue_low write lost")
  `ASSERT_NXT(a_cfg_oor_wr, wr_en && idx != ypc_pkg::REG_HUE_LOW && idx != ypc_pkg::REG_HUE_HIGH && idx != ypc_pkg::REG_SAT_THR && idx != ypc_pkg::REG_VAL_THR && idx != ypc_pkg::REG_GB_MARGIN && idx != ypc_pkg::REG_RB_MARGIN, $stable(cfg_r), "out-of-range write changed registers")
  `ASSERT_NXT(a_cfg_hold, !wr_en, $stable(cfg_r), "registers changed without write")

endmodule

@@ rtl/core/ypc_front.sv @@
// ----------------------------------------------------------------------------
// ypc_front
// Two pipeline stages: max/min/sextant, then divider operands and the
// value and channel-margin checks.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ypc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_blue,
  input  logic [7:0]      in_green,
  input  logic [7:0]      in_red,
  input  ypc_pkg::cfg_t   cfg,
  output ypc_pkg::front_t fo
);

  // stage 1
  logic              s1_valid_r;
  logic [7:0]        s1_blue_r, s1_green_r, s1_red_r;
  logic [7:0]        s1_max_r, s1_min_r;
  ypc_pkg::sext_t    s1_sext_r;
  logic [7:0]        max_nxt, min_nxt;
  ypc_pkg::sext_t    sext_nxt;

  always_comb begin
    if (in_red >= in_green && in_red >= in_blue) begin
      max_nxt  = in_red;
      sext_nxt = ypc_pkg::SEXT_RED;
    end else if (in_green >= in_blue) begin
      max_nxt  = in_green;
      sext_nxt = ypc_pkg::SEXT_GREEN;
    end else begin
      max_nxt  = in_blue;
      sext_nxt = ypc_pkg::SEXT_BLUE;
    end
    min_nxt = in_red;
    if (in_green < min_nxt) min_nxt = in_green;
    if (in_blue < min_nxt) min_nxt = in_blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_blue_r  <= in_blue;
    s1_green_r <= in_green;
    s1_red_r   <= in_red;
    s1_max_r   <= max_nxt;
    s1_min_r   <= min_nxt;
    s1_sext_r  <= sext_nxt;
  end

  // stage 2
  ypc_pkg::front_t     fo_r;
  ypc_pkg::front_t     fo_nxt;
  logic [7:0]          diff;
  logic signed [11:0]  sb, sg, sr, sd, t;
  logic [16:0]         d261;
  logic signed [20:0]  hn;
  logic signed [8:0]   gb_diff, rb_diff;

  always_comb begin
    diff = s1_max_r - s1_min_r;
    sb   = signed'({4'd0, s1_blue_r});
    sg   = signed'({4'd0, s1_green_r});
    sr   = signed'({4'd0, s1_red_r});
    sd   = signed'({4'd0, diff});
    case (s1_sext_r)
      ypc_pkg::SEXT_RED:   t = sg - sb;
      ypc_pkg::SEXT_GREEN: t = sb - sr + (sd <<< 1);
      ypc_pkg::SEXT_BLUE:  t = sr - sg + (sd <<< 2);
      default:             t = 12'sd0;
    endcase
    // hue numerator 256*t + 261*diff, never negative
    d261 = 17'({diff, 8'd0}) + 17'({diff, 2'd0}) + 17'(diff);
    hn   = signed'({t[11], t, 8'd0}) + signed'({4'd0, d261});
    gb_diff = signed'({1'b0, s1_green_r}) - signed'({1'b0, s1_blue_r});
    rb_diff = signed'({1'b0, s1_red_r}) - signed'({1'b0, s1_blue_r});

    fo_nxt.valid   = s1_valid_r;
    fo_nxt.hue_num = hn[ypc_pkg::HUE_NUM_W-1:0];
    fo_nxt.hue_den = ypc_pkg::HUE_DEN_W'({diff, 2'd0}) + ypc_pkg::HUE_DEN_W'({diff, 1'b0});
    fo_nxt.sat_num = 17'({diff, 9'd0}) - 17'({diff, 1'b0}) + 17'(s1_max_r);
    fo_nxt.sat_den = {s1_max_r, 1'b0};
    fo_nxt.grey    = (diff == 8'd0);
    fo_nxt.val_ok  = s1_max_r > cfg.val_thr;
    fo_nxt.gb_ok   = gb_diff > signed'({1'b0, cfg.gb_margin});
    fo_nxt.rb_ok   = rb_diff > signed'({1'b0, cfg.rb_margin});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fo_r.valid <= 1'b0;
    end else begin
      fo_r <= fo_nxt;
    end
  end

  assign fo = fo_r;

  `ASSERT_IMP(a_front_hue_fits, fo_r.valid && !fo_r.grey,
              {1'b0, fo_r.hue_num} < {fo_r.hue_den, 9'd0}, "hue quotient overflow")
  `ASSERT_IMP(a_front_sat_fits, fo_r.valid && !fo_r.grey,
              fo_r.sat_num < {fo_r.sat_den, 8'd0}, "saturation quotient overflow")
  `ASSERT_NXT(a_front_valid, 1'b1, fo_r.valid == $past(s1_valid_r), "stage valid lost")

endmodule

@@ rtl/core/ypc_div.sv @@
// ----------------------------------------------------------------------------
// ypc_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ypc_div #(
  parameter int NUM_W = 19,
  parameter int DEN_W = 11,
  parameter int QUO_W = 9,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [SB_W-1:0]  in_sb,
  output logic             out_valid,
  output logic [QUO_W-1:0] out_quo,
  output logic [SB_W-1:0]  out_sb
);

  localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic             valid_r [QUO_W];
  logic [QUO_W-1:0] quo_r   [QUO_W];
  logic [SB_W-1:0]  sb_r    [QUO_W];
  logic [NUM_W-1:0] rem_r   [QUO_W-1];
  logic [DEN_W-1:0] den_r   [QUO_W-1];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stg
    localparam int BIT = QUO_W - 1 - i;
    logic             cur_valid;
    logic [NUM_W-1:0] cur_rem;
    logic [DEN_W-1:0] cur_den;
    logic [QUO_W-1:0] cur_quo;
    logic [SB_W-1:0]  cur_sb;
    logic [CW-1:0]    rem_ext, sub_ext;
    logic             ge;

    if (i == 0) begin : g_head
      assign cur_valid = in_valid;
      assign cur_rem   = in_num;
      assign cur_den   = in_den;
      assign cur_quo   = '0;
      assign cur_sb    = in_sb;
    end else begin : g_body
      assign cur_valid = valid_r[i-1];
      assign cur_rem   = rem_r[i-1];
      assign cur_den   = den_r[i-1];
      assign cur_quo   = quo_r[i-1];
      assign cur_sb    = sb_r[i-1];
    end

    always_comb begin
      rem_ext = CW'(cur_rem);
      sub_ext = CW'(cur_den) << BIT;
      ge      = rem_ext >= sub_ext;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else begin
        valid_r[i] <= cur_valid;
      end
    end

    always_ff @(posedge clk) begin
      quo_r[i] <= cur_quo | (ge ? (QUO_W'(1) << BIT) : '0);
      sb_r[i]  <= cur_sb;
    end

    if (i < QUO_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[i] <= ge ? NUM_W'(rem_ext - sub_ext) : cur_rem;
        den_r[i] <= cur_den;
      end
    end
  end

  assign out_valid = valid_r[QUO_W-1];
  assign out_quo   = quo_r[QUO_W-1];
  assign out_sb    = sb_r[QUO_W-1];

  `ASSERT_IMP(a_div_latency, in_valid, ##QUO_W out_valid, "divider lost a transaction")
  `ASSERT_IMP(a_div_no_ghost, !in_valid, ##QUO_W !out_valid, "divider invented a transaction")

endmodule

@@ rtl/core/yellow_pixel_classifier.sv @@
// ----------------------------------------------------------------------------
// yellow_pixel_classifier
// Per-pixel HSV threshold mask for a yellow target.
// ----------------------------------------------------------------------------
// Path: ypc_front, then the two dividers, then the final compare register that
// drives out_valid. Throughput: one pixel per cycle; busy is never asserted.
// Most depth lies in the two 9-stage bit-per-cycle hue and saturation dividers.
// Reset: synchronous active-low; clears the pipeline valids and loads the
// default thresholds. Results cannot be stalled by the receiver.
`include "assert_macros.svh"

module yellow_pixel_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_red,
  output logic        out_valid,
  output logic        out_is_yellow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PIPE_LAT = ypc_pkg::PIPE_LATENCY;

  ypc_pkg::cfg_t   cfg;
  ypc_pkg::front_t fo;

  logic                      hue_valid, sat_valid;
  logic [ypc_pkg::QUO_W-1:0] hue_quo, sat_quo;
  logic                      hue_grey;
  logic [2:0]                sat_flags;

  assign busy = 1'b0;

  ypc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ypc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start & ~busy),
    .in_blue  (in_blue),
    .in_green (in_green),
    .in_red   (in_red),
    .cfg      (cfg),
    .fo       (fo)
  );

  ypc_div #(
    .NUM_W (ypc_pkg::HUE_NUM_W),
    .DEN_W (ypc_pkg::HUE_DEN_W),
    .QUO_W (ypc_pkg::QUO_W),
    .SB_W  (1)
  ) u_hue_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fo.valid),
    .in_num    (fo.hue_num),
    .in_den    (fo.hue_den),
    .in_sb     (fo.grey),
    .out_valid (hue_valid),
    .out_quo   (hue_quo),
    .out_sb    (hue_grey)
  );

  ypc_div #(
    .NUM_W (ypc_pkg::SAT_NUM_W),
    .DEN_W (ypc_pkg::SAT_DEN_W),
    .QUO_W (ypc_pkg::QUO_W),
    .SB_W  (3)
  ) u_sat_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fo.valid),
    .in_num    (fo.sat_num),
    .in_den    (fo.sat_den),
    .in_sb     ({fo.val_ok, fo.gb_ok, fo.rb_ok}),
    .out_valid (sat_valid),
    .out_quo   (sat_quo),
    .out_sb    (sat_flags)
  );

  // final compare stage
  logic       out_valid_r, out_valid_nxt;
  logic       out_is_yellow_r, out_is_yellow_nxt;
  logic [7:0] hue, sat;

  always_comb begin
    hue = hue_grey ? 8'd0 : hue_quo[7:0] - ypc_pkg::HUE_BIAS;
    sat = hue_grey ? 8'd0 : sat_quo[7:0];
    out_valid_nxt     = hue_valid;
    out_is_yellow_nxt = hue_valid && hue >= cfg.hue_low && hue <= cfg.hue_high &&
                        sat > cfg.sat_thr && (&sat_flags);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      out_is_yellow_r <= 1'b0;
    end else begin
      out_valid_r     <= out_valid_nxt;
      out_is_yellow_r <= out_is_yellow_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_is_yellow = out_is_yellow_r;

  `ASSERT_IMP(a_top_div_align, 1'b1, hue_valid == sat_valid, "divider lanes out of step")
  `ASSERT_IMP(a_top_latency, start && !busy, ##PIPE_LAT out_valid, "transaction lost")
  `ASSERT_IMP(a_top_mask_qual, out_is_yellow, out_valid, "mask without strobe")

endmodule

@@ bench/ypc_checker.sv @@
// ----------------------------------------------------------------------------
// ypc_checker
// Watches the pixel, mask and register ports of the yellow pixel classifier.
// It keeps its own copy of the thresholds, predicts the mask of every
// accepted pixel and compares each result strobe with the oldest prediction.
// It reports the number of outstanding pixels and the failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ypc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_red,
  input  logic        out_valid,
  input  logic        out_is_yellow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          pending,
  output int          errors
);

  typedef struct {
    bit         mask;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } mask_exp_t;

  logic [7:0] thr [0:5];
  mask_exp_t  mask_q[$];
  mask_exp_t  head;
  mask_exp_t  fresh;
  bit         took;
  bit         gave;

  function automatic bit classify(input logic [7:0] b, input logic [7:0] g,
                                  input logic [7:0] r);
    int blu, grn, red, vmax, vmin, span, sector, sat, hue, num, den;
    blu  = int'(b);
    grn  = int'(g);
    red  = int'(r);
    vmax = red;
    vmin = red;
    if (grn > vmax) vmax = grn;
    if (blu > vmax) vmax = blu;
    if (grn < vmin) vmin = grn;
    if (blu < vmin) vmin = blu;
    span = vmax - vmin;
    sat  = 0;
    hue  = 0;
    if (span > 0) begin
      sat = (510 * span + vmax) / (2 * vmax);
      if (vmax == red) sector = grn - blu;
      else if (vmax == grn) sector = blu - red + 2 * span;
      else sector = red - grn + 4 * span;
      // bias by 43 hue steps so the rounding division stays non-negative
      den = 12 * span;
      num = sector * 512 + 6 * span + 43 * den;
      hue = (num / den - 43) & 255;
    end
    return (hue >= int'(thr[ypc_pkg::REG_HUE_LOW]))
        && (hue <= int'(thr[ypc_pkg::REG_HUE_HIGH]))
        && (sat > int'(thr[ypc_pkg::REG_SAT_THR]))
        && (vmax > int'(thr[ypc_pkg::REG_VAL_THR]))
        && ((grn - blu) > int'(thr[ypc_pkg::REG_GB_MARGIN]))
        && ((red - blu) > int'(thr[ypc_pkg::REG_RB_MARGIN]));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      thr[ypc_pkg::REG_HUE_LOW]   = ypc_pkg::RST_HUE_LOW;
      thr[ypc_pkg::REG_HUE_HIGH]  = ypc_pkg::RST_HUE_HIGH;
      thr[ypc_pkg::REG_SAT_THR]   = ypc_pkg::RST_SAT_THR;
      thr[ypc_pkg::REG_VAL_THR]   = ypc_pkg::RST_VAL_THR;
      thr[ypc_pkg::REG_GB_MARGIN] = ypc_pkg::RST_GB_MARGIN;
      thr[ypc_pkg::REG_RB_MARGIN] = ypc_pkg::RST_RB_MARGIN;
      mask_q.delete();
      pending <= 0;
    end else begin
      took = (start === 1'b1) && (busy === 1'b0);
      gave = (out_valid === 1'b1);
      if (gave) begin
        if (mask_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected mask transaction, expected none, actual %b",
                   $time, out_is_yellow);
        end else begin
          head = mask_q.pop_front();
          if (out_is_yellow !== head.mask) begin
            errors++;
            $display("%0t: is_yellow mismatch for bgr %0d,%0d,%0d: expected %b actual %b",
                     $time, head.b, head.g, head.r, head.mask, out_is_yellow);
          end
        end
      end
      if (took) begin
        fresh = '{classify(in_blue, in_green, in_red), in_blue, in_green, in_red};
        mask_q.insert(mask_q.size(), fresh);
      end
      if (psel && penable && pwrite && pready && (paddr[4:2] <= ypc_pkg::REG_RB_MARGIN))
        thr[paddr[4:2]] = pwdata[7:0];
      pending <= pending + int'(took) - int'(gave);
    end
  end

endmodule

@@ bench/yellow_pixel_classifier_tb.sv @@
// ----------------------------------------------------------------------------
// yellow_pixel_classifier_tb
// Drives pixels and threshold writes into the yellow pixel classifier.
// A directed set covers grey, primary and boundary pixels, then random
// phases run under default, extreme, empty-window and random thresholds,
// with random start gaps and back-to-back bursts. ypc_checker judges results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module yellow_pixel_classifier_tb;

  localparam int         CYCLE_LIMIT = 100000;
  localparam int         PHASE_ITEMS = 72;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [7:0]  in_blue;
  logic [7:0]  in_green;
  logic [7:0]  in_red;
  logic        out_valid;
  logic        out_is_yellow;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          pending;
  int          errors;
  int          cycles;
  bit          burst;

  yellow_pixel_classifier DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_blue(in_blue), .in_green(in_green), .in_red(in_red),
    .out_valid(out_valid), .out_is_yellow(out_is_yellow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ypc_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_blue(in_blue), .in_green(in_green), .in_red(in_red),
    .out_valid(out_valid), .out_is_yellow(out_is_yellow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .pending(pending), .errors(errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("yellow_pixel_classifier test failed");
      $finish;
    end
  end

  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g,
                            input logic [7:0] r);
    int gap;
    if ($urandom_range(0, 19) == 0) burst = !burst;
    gap = burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_blue  <= b;
    in_green <= g;
    in_red   <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic random_pixel();
    int          kind;
    logic [7:0]  lvl;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      send_pixel(8'($urandom_range(0, 120)), 8'($urandom_range(100, 255)),
                 8'($urandom_range(100, 255)));
    end else if (kind < 9) begin
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      lvl = 8'($urandom);
      send_pixel(lvl, lvl, lvl);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_thresholds(input logic [7:0] lo, input logic [7:0] hi,
                                    input logic [7:0] sat, input logic [7:0] val,
                                    input logic [7:0] gb, input logic [7:0] rb);
    drain();
    write_reg(ypc_pkg::REG_HUE_LOW, lo);
    write_reg(ypc_pkg::REG_HUE_HIGH, hi);
    write_reg(ypc_pkg::REG_SAT_THR, sat);
    write_reg(ypc_pkg::REG_VAL_THR, val);
    write_reg(ypc_pkg::REG_GB_MARGIN, gb);
    write_reg(ypc_pkg::REG_RB_MARGIN, rb);
    if ($urandom_range(0, 1)) write_reg(REG_SPARE_LO, 8'($urandom));
    else write_reg(REG_SPARE_HI, 8'($urandom));
  endtask

  task automatic random_phase();
    repeat (PHASE_ITEMS) random_pixel();
  endtask

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    in_blue  = 8'd0;
    in_green = 8'd0;
    in_red   = 8'd0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = 5'd0;
    pwdata   = 32'd0;
    burst    = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pixels under reset thresholds, bgr order
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd0,   8'd200, 8'd255);
    send_pixel(8'd10,  8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd200, 8'd255, 8'd255);
    send_pixel(8'd100, 8'd50,  8'd255);
    send_pixel(8'd60,  8'd150, 8'd200);
    send_pixel(8'd0,   8'd255, 8'd128);
    send_pixel(8'd0,   8'd1,   8'd1);
    send_pixel(8'd0,   8'd111, 8'd111);
    send_pixel(8'd0,   8'd110, 8'd110);
    send_pixel(8'd0,   8'd60,  8'd120);
    send_pixel(8'd0,   8'd255, 8'd254);
    send_pixel(8'd36,  8'd71,  8'd57);
    random_phase();

    program_thresholds(8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
    random_phase();
    program_thresholds(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    random_phase();
    // empty hue window
    program_thresholds(8'd200, 8'd100, 8'd10, 8'd10, 8'd0, 8'd0);
    random_phase();
    program_thresholds(8'($urandom_range(0, 60)), 8'($urandom_range(30, 255)),
                       8'($urandom_range(0, 160)), 8'($urandom_range(0, 160)),
                       8'($urandom_range(0, 80)), 8'($urandom_range(0, 80)));
    random_phase();
    program_thresholds(ypc_pkg::RST_HUE_LOW, ypc_pkg::RST_HUE_HIGH,
                       ypc_pkg::RST_SAT_THR, ypc_pkg::RST_VAL_THR,
                       ypc_pkg::RST_GB_MARGIN, ypc_pkg::RST_RB_MARGIN);
    random_phase();

    drain();
    repeat (ypc_pkg::PIPE_LATENCY + 4) @(posedge clk);
    if (errors == 0) begin
      $display("yellow_pixel_classifier test passed");
    end else begin
      $display("yellow_pixel_classifier test failed");
    end
    $finish;
  end

endmodule
